// ----- rtl/ersi_pkg.sv -----
// shared types and constants for the ema and rsi trend signal unit
`timescale 1ns / 1ps
package ersi_pkg;

   localparam int PRICE_W = 32;
   localparam int AVG_W = 56;
   localparam int DIV_W = 64;
   localparam logic [8:0] ITEMS_MAX = 9'd511;
   localparam logic [8:0] WARMUP_EXTRA = 9'd10;
   localparam logic [14:0] RSI_NEUTRAL = 15'd12800;
   localparam logic [14:0] RSI_FULL = 15'd25600;

   localparam logic [1:0] CSR_EMA_PERIOD = 2'd0;
   localparam logic [1:0] CSR_RSI_PERIOD = 2'd1;
   localparam logic [1:0] CSR_OVERSOLD = 2'd2;
   localparam logic [1:0] CSR_OVERBOUGHT = 2'd3;

   localparam logic [1:0] SIG_NONE = 2'd0;
   localparam logic [1:0] SIG_BUY = 2'd1;
   localparam logic [1:0] SIG_SELL = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MDIV,
      ST_EMA_SEED_RD,
      ST_EMA_SEED,
      ST_EMA_RD,
      ST_EMA_MUL,
      ST_EMA_ACC,
      ST_RSI_RD_A,
      ST_RSI_RD_B,
      ST_RSI_SUM,
      ST_RSI_DIVG,
      ST_RSI_DIVL,
      ST_RSI_SM_RD_A,
      ST_RSI_SM_RD_B,
      ST_RSI_SM_MULG,
      ST_RSI_SM_DIVG,
      ST_RSI_SM_MULL,
      ST_RSI_SM_DIVL,
      ST_RSI_FIN_MUL,
      ST_RSI_FIN_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/ersi_divider.sv -----
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ersi_divider
   import ersi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_W:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in = req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = 7'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff && !$past(req.start))) else $error("divider done while busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 7'd0) else $error("divider count left over");
`endif

endmodule

// ----- rtl/ema_rsi_trend_signal_unit.sv -----
// top level: price window, sequencer and datapath around one shared divider
// the time from acceptance to the result word grows with ema_period and the wilder period n
// a neutral rsi skips the wilder sums, a zero ema period the ema; warm-up words skip both
// every division runs on the shared 64-bit divider
// one word at a time: req_tready stays low until the result is loaded into the output register
// reset (synchronous, active high) clears control, counters, csrs; datapath, window undefined
`timescale 1ns / 1ps
module ema_rsi_trend_signal_unit
   import ersi_pkg::*;
#(
   parameter int WINDOW_DEPTH = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // close_price
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // signal, history_ready, ema_value, rsi_value, zero fill
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [PRICE_W-1:0] window_mem [WINDOW_DEPTH];
   logic [PRICE_W-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;

   state_type state_ff, state_in;

   logic [7:0] ema_period_ff;
   logic [6:0] wilder_n_ff;
   logic [14:0] oversold_ff, overbought_ff;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [8:0] seen_ff, seen_in;
   logic [8:0] idx_ff, idx_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [24:0] mult_ff, mult_in;
   logic [PRICE_W-1:0] ema_ff, ema_in;
   logic [PRICE_W-1:0] diff_ff, diff_in;
   logic up_ff, up_in;
   logic [56:0] prod_ff, prod_in;
   logic [8:0] k_ff, k_in;
   logic [PRICE_W-1:0] a_ff, a_in;
   logic [39:0] sg_ff, sg_in, sl_ff, sl_in;
   logic [AVG_W-1:0] ag_ff, ag_in, al_ff, al_in;
   logic [14:0] rsi_ff, rsi_in;
   logic [1:0] sig_ff, sig_in;
   logic ready_ff, ready_in;
   logic [55:0] out_ff, out_in;
   logic ovalid_ff, ovalid_in;
   div_req_type dreq;
   div_rsp_type drsp;
   logic wr_en;
   logic [PRICE_W-1:0] gain, loss;
   logic [8:0] look;
   logic [PRICE_W-1:0] ema_sel;

   ersi_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign look = {1'b0, wilder_n_ff, 1'b0};
   assign wr_en = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign gain = (a_ff > rd_data_ff) ? a_ff - rd_data_ff : '0;
   assign loss = (rd_data_ff > a_ff) ? rd_data_ff - a_ff : '0;

   // window memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) window_mem[wpos_ff] <= req_tdata;
      rd_data_ff <= window_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ema_period_ff <= 8'd50;
         wilder_n_ff <= 7'd14;
         oversold_ff <= 15'd7680;
         overbought_ff <= 15'd17920;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EMA_PERIOD: ema_period_ff <= csr_wdata[7:0];
            CSR_RSI_PERIOD: wilder_n_ff <= csr_wdata[6:0];
            CSR_OVERSOLD:   oversold_ff <= csr_wdata;
            CSR_OVERBOUGHT: overbought_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (wr_en) begin
               if ({1'b0, seen_ff} < {1'b0, ema_period_ff} + 10'(WARMUP_EXTRA))
                  state_in = ST_DONE;
               else if (ema_period_ff == 8'd0)
                  state_in = ST_RSI_RD_A;
               else
                  state_in = ST_MDIV;
            end
         ST_MDIV:        if (drsp.done) state_in = ST_EMA_SEED_RD;
         ST_EMA_SEED_RD: state_in = ST_EMA_SEED;
         ST_EMA_SEED:    state_in = ST_EMA_MUL;
         ST_EMA_RD:      state_in = ST_EMA_MUL;
         ST_EMA_MUL:     state_in = ST_EMA_ACC;
         ST_EMA_ACC:     state_in = (k_ff == 9'd0) ? ST_RSI_RD_A : ST_EMA_RD;
         ST_RSI_RD_A:
            if (wilder_n_ff == 7'd0 || idx_ff < look) state_in = ST_RSI_FIN_DIV;
            else state_in = ST_RSI_RD_B;
         ST_RSI_RD_B:    state_in = ST_RSI_SUM;
         ST_RSI_SUM:     state_in = (k_ff == {2'b0, wilder_n_ff}) ? ST_RSI_DIVG : ST_RSI_RD_A;
         ST_RSI_DIVG:    if (drsp.done) state_in = ST_RSI_DIVL;
         ST_RSI_DIVL:    if (drsp.done) state_in = ST_RSI_SM_RD_A;
         ST_RSI_SM_RD_A: state_in = ST_RSI_SM_RD_B;
         ST_RSI_SM_RD_B: state_in = ST_RSI_SM_MULG;
         ST_RSI_SM_MULG: state_in = ST_RSI_SM_DIVG;
         ST_RSI_SM_DIVG: if (drsp.done) state_in = ST_RSI_SM_MULL;
         ST_RSI_SM_MULL: state_in = ST_RSI_SM_DIVL;
         ST_RSI_SM_DIVL:
            if (drsp.done) state_in = (k_ff == look) ? ST_RSI_FIN_MUL : ST_RSI_SM_RD_A;
         ST_RSI_FIN_MUL: state_in = (al_ff == '0) ? ST_DONE : ST_RSI_FIN_DIV;
         ST_RSI_FIN_DIV:
            if (wilder_n_ff == 7'd0 || idx_ff < look || al_ff == '0) state_in = ST_DONE;
            else if (drsp.done) state_in = ST_DONE;
         ST_DONE:        state_in = ST_OUT;
         ST_OUT:         if (!ovalid_ff || rsp_tready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wpos_in = wpos_ff; cur_in = cur_ff; seen_in = seen_ff; idx_in = idx_ff;
      price_in = price_ff; mult_in = mult_ff; ema_in = ema_ff; diff_in = diff_ff;
      up_in = up_ff; prod_in = prod_ff; k_in = k_ff; a_in = a_ff;
      sg_in = sg_ff; sl_in = sl_ff; ag_in = ag_ff; al_in = al_ff;
      rsi_in = rsi_ff; sig_in = sig_ff; ready_in = ready_ff;
      out_in = out_ff; ovalid_in = ovalid_ff;
      dreq = '{start: 1'b0, num: '0, den: 64'd1};
      rd_addr = cur_ff;
      ema_sel = ema_ff;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE:
            if (wr_en) begin
               price_in = req_tdata;
               cur_in = wpos_ff;
               wpos_in = AW'(wpos_ff + AW'(1));
               idx_in = seen_ff;
               seen_in = (seen_ff < ITEMS_MAX) ? seen_ff + 9'd1 : ITEMS_MAX;
               ema_in = req_tdata;
               ready_in = 1'b0;
               rsi_in = '0;
               sig_in = SIG_NONE;
               if ({1'b0, seen_ff} < {1'b0, ema_period_ff} + 10'(WARMUP_EXTRA))
                  ema_in = '0;
               else begin
                  ready_in = 1'b1;
                  dreq.start = (ema_period_ff != 8'd0);
                  dreq.num = 64'd1 << 25;
                  dreq.den = 64'(ema_period_ff) + 64'd1;
               end
               k_in = 9'd1;
               sg_in = '0; sl_in = '0;
            end
         ST_MDIV: begin
            mult_in = drsp.quo[24:0];
            k_in = {1'b0, ema_period_ff};
         end
         ST_EMA_SEED_RD: rd_addr = AW'(cur_ff - AW'(k_ff));
         ST_EMA_SEED: begin
            ema_in = rd_data_ff;
            k_in = k_ff - 9'd1;
            up_in = (price_ff >= rd_data_ff);
            rd_addr = AW'(cur_ff - AW'(k_ff - 9'd1));
         end
         ST_EMA_RD: rd_addr = AW'(cur_ff - AW'(k_ff));
         ST_EMA_MUL: begin
            up_in = (rd_data_ff >= ema_ff);
            diff_in = up_in ? rd_data_ff - ema_ff : ema_ff - rd_data_ff;
            prod_in = 57'(diff_in) * 57'(mult_ff);
            k_in = k_ff;
         end
         ST_EMA_ACC: begin
            ema_in = up_ff ? ema_ff + prod_ff[55:24] : ema_ff - prod_ff[55:24];
            if (k_ff != 9'd0) k_in = k_ff - 9'd1;
            else k_in = 9'd1;
         end
         ST_RSI_RD_A: rd_addr = AW'(cur_ff - AW'(look - k_ff));
         ST_RSI_RD_B: begin
            a_in = rd_data_ff;
            rd_addr = AW'(cur_ff - AW'(look - k_ff + 9'd1));
         end
         ST_RSI_SUM: begin
            sg_in = sg_ff + 40'(gain);
            sl_in = sl_ff + 40'(loss);
            if (k_ff == {2'b0, wilder_n_ff}) begin
               dreq.start = 1'b1;
               dreq.num = 64'(sg_in) << 8;
               dreq.den = 64'(wilder_n_ff);
            end
            k_in = k_ff + 9'd1;
         end
         ST_RSI_DIVG:
            if (drsp.done) begin
               ag_in = drsp.quo[AVG_W-1:0];
               dreq.start = 1'b1;
               dreq.num = 64'(sl_ff) << 8;
               dreq.den = 64'(wilder_n_ff);
            end
         ST_RSI_DIVL: if (drsp.done) al_in = drsp.quo[AVG_W-1:0];
         ST_RSI_SM_RD_A: rd_addr = AW'(cur_ff - AW'(look - k_ff));
         ST_RSI_SM_RD_B: begin
            a_in = rd_data_ff;
            rd_addr = AW'(cur_ff - AW'(look - k_ff + 9'd1));
         end
         ST_RSI_SM_MULG: begin
            diff_in = loss;
            prod_in = 57'(ag_ff[31:0]) * 57'(wilder_n_ff - 7'd1);
            dreq.start = 1'b1;
            dreq.num = 64'(ag_ff) * 64'(wilder_n_ff - 7'd1) + (64'(gain) << 8);
            dreq.den = 64'(wilder_n_ff);
         end
         ST_RSI_SM_DIVG: if (drsp.done) ag_in = drsp.quo[AVG_W-1:0];
         ST_RSI_SM_MULL: begin
            dreq.start = 1'b1;
            dreq.num = 64'(al_ff) * 64'(wilder_n_ff - 7'd1) + (64'(diff_ff) << 8);
            dreq.den = 64'(wilder_n_ff);
         end
         ST_RSI_SM_DIVL:
            if (drsp.done) begin
               al_in = drsp.quo[AVG_W-1:0];
               k_in = k_ff + 9'd1;
            end
         ST_RSI_FIN_MUL:
            if (al_ff == '0) rsi_in = RSI_FULL;
            else begin
               dreq.start = 1'b1;
               dreq.num = 64'(ag_ff) * 64'(RSI_FULL);
               dreq.den = 64'(ag_ff) + 64'(al_ff);
            end
         ST_RSI_FIN_DIV:
            if (wilder_n_ff == 7'd0 || idx_ff < look) rsi_in = RSI_NEUTRAL;
            else if (drsp.done) rsi_in = drsp.quo[14:0];
         ST_DONE:
            if (ready_ff) begin
               if (price_ff > ema_sel) begin
                  if (rsi_ff < oversold_ff) sig_in = SIG_BUY;
               end else if (price_ff < ema_sel) begin
                  if (rsi_ff > overbought_ff) sig_in = SIG_SELL;
               end
            end else begin
               rsi_in = '0;
            end
         ST_OUT:
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               out_in = {6'b0, rsi_ff, ema_ff, ready_ff, sig_ff};
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff <= '0;
         seen_ff <= '0;
         ovalid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         wpos_ff <= wpos_in;
         seen_ff <= seen_in;
         ovalid_ff <= ovalid_in;
         k_ff <= k_in;
      end
      cur_ff <= cur_in; idx_ff <= idx_in; price_ff <= price_in; mult_ff <= mult_in;
      ema_ff <= ema_in; diff_ff <= diff_in; up_ff <= up_in; prod_ff <= prod_in;
      a_ff <= a_in; sg_ff <= sg_in; sl_ff <= sl_in; ag_ff <= ag_in; al_ff <= al_in;
      rsi_ff <= rsi_in; sig_ff <= sig_in; ready_ff <= ready_in; out_ff <= out_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = out_ff;

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !req_tready) else $error("word accepted while busy");
   a_seen_sat: assert property (@(posedge clock) disable iff (reset)
      wr_en && seen_ff == ITEMS_MAX |=> seen_ff == ITEMS_MAX) else $error("count wrapped");
   a_warmup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[55:0] == 56'd0) else $error("warm-up word not zero");
`endif

endmodule
